/* rtl/core/spr_pkg.sv */
// ----------------------------------------------------------------------------
// spr_pkg
// types and constants shared by the sequenced packet receiver modules
// ----------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

	localparam int NUM_SLOTS     = 4;
	localparam int PAYLOAD_BYTES = 64;
	localparam int HDR_BYTES     = 3;
	// the type table has four entries, slots beyond it never match
	localparam int TABLE_SLOTS   = 4;
	localparam int MATCH_SLOTS   = (NUM_SLOTS < TABLE_SLOTS) ? NUM_SLOTS : TABLE_SLOTS;

	localparam logic [7:0] PING_LEN = 8'(HDR_BYTES);
	localparam logic [7:0] DATA_LEN = 8'(PAYLOAD_BYTES + HDR_BYTES);
	localparam logic [7:0] SEQ_OPEN = 8'd0;

	typedef enum logic [2:0] {
		CFG_PING_CODE = 3'd0,
		CFG_PROTO_A   = 3'd1,
		CFG_PROTO_B   = 3'd2,
		CFG_PROTO_C   = 3'd3,
		CFG_PROTO_D   = 3'd4,
		CFG_SLOT_EN   = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]                  ping_code;
		logic [TABLE_SLOTS-1:0][7:0] proto_type;
		logic [TABLE_SLOTS-1:0]      slot_enable;
	} cfg_t;

	typedef struct packed {
		logic [7:0] pkt_len;
		logic [7:0] pkt_type;
		logic [7:0] pkt_seq;
		logic [7:0] pkt_limit;
		logic       handler_ok;
	} hdr_t;

	typedef struct packed {
		logic       accepted;
		logic       ack_send;
		logic [7:0] ack_type;
		logic [7:0] ack_seq;
		logic       pong_send;
		logic       handler_call;
		logic [1:0] handler_slot;
	} res_t;

endpackage

`default_nettype wire

/* rtl/core/spr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// spr_cfg_regs
// configuration register file: ping code, slot type table and slot enables
// ----------------------------------------------------------------------------
`default_nettype none

module spr_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [7:0]    cfg_data,
	output spr_pkg::cfg_t      cfg
);

	spr_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (spr_pkg::cfg_idx_t'(cfg_index))
				spr_pkg::CFG_PING_CODE: cfg_q.ping_code     <= cfg_data;
				spr_pkg::CFG_PROTO_A:   cfg_q.proto_type[0] <= cfg_data;
				spr_pkg::CFG_PROTO_B:   cfg_q.proto_type[1] <= cfg_data;
				spr_pkg::CFG_PROTO_C:   cfg_q.proto_type[2] <= cfg_data;
				spr_pkg::CFG_PROTO_D:   cfg_q.proto_type[3] <= cfg_data;
				spr_pkg::CFG_SLOT_EN:   cfg_q.slot_enable   <= cfg_data[spr_pkg::TABLE_SLOTS-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/spr_session.sv */
// ----------------------------------------------------------------------------
// spr_session
// header checks, slot lookup and session state for one received word
// ----------------------------------------------------------------------------
`default_nettype none

module spr_session (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire spr_pkg::cfg_t cfg,
	input  wire spr_pkg::hdr_t hdr,
	input  wire logic          upd,
	output spr_pkg::res_t      res
);

	logic       open_q;
	logic [7:0] type_q;
	logic [1:0] slot_q;
	logic [7:0] exp_q;
	logic [7:0] limit_q;

	logic       is_ping;
	logic       is_data;
	logic       found;
	logic [1:0] found_slot;
	logic       in_session;
	logic       is_repeat;
	logic       is_next;
	logic       do_open;
	logic       do_next;

	// lowest enabled slot with a matching type wins
	always_comb begin
		found      = 1'b0;
		found_slot = '0;
		for (int s = spr_pkg::MATCH_SLOTS - 1; s >= 0; s--) begin
			if (cfg.slot_enable[s] && cfg.proto_type[s] == hdr.pkt_type) begin
				found      = 1'b1;
				found_slot = 2'(s);
			end
		end
	end

	always_comb begin
		is_ping    = (hdr.pkt_len == spr_pkg::PING_LEN) && (hdr.pkt_type == cfg.ping_code);
		is_data    = !is_ping && (hdr.pkt_len == spr_pkg::DATA_LEN);
		in_session = open_q && (hdr.pkt_type == type_q) && (hdr.pkt_limit == limit_q)
			&& (hdr.pkt_seq <= limit_q);
		// nine-bit compare so 255 never counts as a repeat
		is_repeat  = ({1'b0, hdr.pkt_seq} + 9'd1) == {1'b0, exp_q};
		is_next    = hdr.pkt_seq == exp_q;

		res = '0;
		do_open = 1'b0;
		do_next = 1'b0;
		if (is_ping) begin
			res.pong_send = (hdr.pkt_seq == spr_pkg::SEQ_OPEN);
		end else if (is_data) begin
			if (hdr.pkt_seq == spr_pkg::SEQ_OPEN) begin
				if (found) begin
					res.handler_call = 1'b1;
					res.handler_slot = found_slot;
					do_open          = hdr.handler_ok;
				end
			end else if (in_session) begin
				if (is_repeat) begin
					res.ack_send = 1'b1;
				end else if (is_next) begin
					res.handler_call = 1'b1;
					res.handler_slot = slot_q;
					do_next          = hdr.handler_ok;
				end
			end
		end
		if (do_open || do_next) begin
			res.accepted = 1'b1;
			res.ack_send = 1'b1;
		end
		if (res.ack_send) begin
			res.ack_type = 8'(hdr.pkt_type + 8'd1);
			res.ack_seq  = hdr.pkt_seq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			type_q  <= '0;
			slot_q  <= '0;
			exp_q   <= '0;
			limit_q <= '0;
		end else if (upd) begin
			if (do_open) begin
				open_q  <= 1'b1;
				type_q  <= hdr.pkt_type;
				slot_q  <= found_slot;
				exp_q   <= 8'd1;
				limit_q <= hdr.pkt_limit;
			end else if (do_next) begin
				exp_q <= 8'(exp_q + 8'd1);
			end
		end
	end

	a_accept_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && res.accepted) |=> open_q)
		else $error("accepted word did not leave a session open");

	a_next_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && res.accepted && hdr.pkt_seq != spr_pkg::SEQ_OPEN)
		|=> exp_q == 8'($past(exp_q) + 8'd1))
		else $error("expected sequence did not advance");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> $stable(exp_q) && $stable(open_q) && $stable(type_q))
		else $error("session state changed without a word");

	a_pong_alone: assert property (@(posedge clk) disable iff (!arst_n)
		res.pong_send |-> !res.handler_call && !res.ack_send && !res.accepted)
		else $error("pong raised together with data handling");

	a_open_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && res.accepted && hdr.pkt_seq == spr_pkg::SEQ_OPEN)
		|-> cfg.slot_enable[res.handler_slot])
		else $error("session opened on a disabled slot");

endmodule

`default_nettype wire

/* rtl/core/sequenced_packet_receiver.sv */
// ----------------------------------------------------------------------------
// sequenced_packet_receiver
// receiving side of a stop-and-wait link: checks headers, tracks one session
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    pkt_len pkt_type pkt_seq pkt_limit handler_ok
//  result    out        out_valid / out_stall  accepted ack_* pong_send handler_*
//  config    in         cfg_valid / cfg_ready  cfg_index cfg_data
//
//  one word per cycle sustained while out_stall is low; a result is worked out from
//  its word in the input register and presented from the result register
//  the session compare and four-way type lookup sit between the two registers
//  reset clears the configuration, the session and both valid flags
//  in_stall rises only when both registers hold words and out_stall is high
//
`default_nettype none

module sequenced_packet_receiver (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] pkt_len,
	input  wire logic [7:0] pkt_type,
	input  wire logic [7:0] pkt_seq,
	input  wire logic [7:0] pkt_limit,
	input  wire logic       handler_ok,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            accepted,
	output logic            ack_send,
	output logic [7:0]      ack_type,
	output logic [7:0]      ack_seq,
	output logic            pong_send,
	output logic            handler_call,
	output logic [1:0]      handler_slot,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	spr_pkg::cfg_t cfg;
	spr_pkg::hdr_t hdr_s1;
	spr_pkg::res_t res;
	spr_pkg::res_t res_s2;
	logic          vld_s1;
	logic          vld_s2;
	logic          adv_s2;
	logic          adv_s1;

	spr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// result register frees when empty or taken this cycle
	assign adv_s2   = !vld_s2 || !out_stall;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_stall = !adv_s1;

	spr_session u_session (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.hdr    (hdr_s1),
		.upd    (vld_s1 && adv_s2),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				vld_s1 <= in_valid;
			if (adv_s2)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid)
			hdr_s1 <= '{pkt_len: pkt_len, pkt_type: pkt_type, pkt_seq: pkt_seq,
				pkt_limit: pkt_limit, handler_ok: handler_ok};
		if (adv_s2 && vld_s1)
			res_s2 <= res;
	end

	assign out_valid    = vld_s2;
	assign accepted     = res_s2.accepted;
	assign ack_send     = res_s2.ack_send;
	assign ack_type     = res_s2.ack_type;
	assign ack_seq      = res_s2.ack_seq;
	assign pong_send    = res_s2.pong_send;
	assign handler_call = res_s2.handler_call;
	assign handler_slot = res_s2.handler_slot;

endmodule

`default_nettype wire
